// File: rtl/aac_pkg.sv
// Shared types, widths and constants of the accelerometer activity classifier.
`default_nettype none

package aac_pkg;

   localparam int unsigned NUM_AXES    = 3;
   localparam int unsigned AXIS_W      = 16;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned SQ_W        = 32;
   localparam int unsigned ROOT_W      = 16;
   localparam int unsigned LEVEL_W     = 24;
   localparam int unsigned DIFF_W      = LEVEL_W + 1;
   localparam int unsigned PROD_W      = LEVEL_W + 18;
   localparam int unsigned SUM_W       = 24;
   localparam int unsigned COUNT_W     = 8;
   localparam int unsigned STEP_W      = 4;

   localparam logic [SQ_W-1:0]       ROOT_FIRST_BIT = 32'h4000_0000;
   localparam logic [LEVEL_W-1:0]    LEVEL_RESET    = 24'd642908;
   localparam logic [AXIS_W-1:0]     BIAS_X_RESET   = 16'd58;
   localparam logic [AXIS_W-1:0]     BIAS_Y_RESET   = 16'd79;
   localparam logic [AXIS_W-1:0]     BIAS_Z_RESET   = 16'hEEA9;
   localparam logic [CSR_DATA_W-1:0] ALPHA_RESET    = 16'd3277;
   localparam logic [CSR_DATA_W-1:0] PEAK_RESET     = 16'd1280;
   localparam logic [CSR_DATA_W-1:0] RUN_RESET      = 16'd896;
   localparam logic [CSR_DATA_W-1:0] WALK_RESET     = 16'd307;
   localparam logic [COUNT_W-1:0]    WINDOW_RESET   = 8'd70;
   localparam logic [COUNT_W-1:0]    RUN_PEAKS      = 8'd3;
   localparam logic [COUNT_W-1:0]    COUNT_MAX      = 8'hFF;
   localparam logic [STEP_W-1:0]     LAST_STEP      = 4'hF;

   typedef enum logic [1:0] {
      ACT_REST = 2'd0,
      ACT_WALK = 2'd1,
      ACT_RUN  = 2'd2
   } activity_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_BIAS_X = 3'd0,
      REG_BIAS_Y = 3'd1,
      REG_BIAS_Z = 3'd2,
      REG_ALPHA  = 3'd3,
      REG_PEAK   = 3'd4,
      REG_RUN    = 3'd5,
      REG_WALK   = 3'd6,
      REG_WINDOW = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_SMOOTH,
      ST_DEVIATION,
      ST_UPDATE,
      ST_SCALE,
      ST_CLASSIFY,
      ST_RESPOND
   } state_type;

endpackage

`default_nettype wire

// File: rtl/aac_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none

module aac_isqrt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [aac_pkg::SQ_W-1:0]   radicand,
   output logic                            done,
   output logic [aac_pkg::ROOT_W-1:0]      root
);
   import aac_pkg::*;

   logic [SQ_W-1:0] rem_ff, rem_in;
   logic [SQ_W-1:0] res_ff, res_in;
   logic [SQ_W-1:0] bit_ff, bit_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [SQ_W-1:0] trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = ROOT_FIRST_BIT;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         // The weight-one bit is the last of the sixteen iterations.
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule

`default_nettype wire

// File: rtl/accel_activity_classifier_top.sv
// Top level of the accelerometer activity classifier.
`default_nettype none

// Usage:
// A request carries one three-axis acceleration sample (req_accel_x/y/z, Q7.8)
// on a valid/ready channel. Each request yields exactly one response on the
// rsp_ channel: the bias-corrected magnitude, the current activity class and
// a flag that tells whether this sample closed a classification window.
// The block works on one request at a time. From acceptance to a valid
// response it runs bit-serial squaring (three axes in parallel lanes), starts
// and runs the two-bits-per-cycle square root, runs the bit-serial multiply
// for the exponential average and takes five steps for deviation, counters,
// threshold scaling, classification and the response load. A new request can
// be accepted in the cycle after the previous response is loaded. The response
// sits in an output register; the block accepts and processes the next request
// while that response waits. If the receiver still stalls when the next
// response is ready, the block holds it until the register frees. The
// synchronous reset restores the configuration registers, the state, the
// window counters and response valid, sets the average to 9.81 m/s^2 and
// selects rest. Configuration writes take effect at once and belong to idle
// periods.
module accel_activity_classifier_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [aac_pkg::AXIS_W-1:0] req_accel_x,
   input  wire logic signed [aac_pkg::AXIS_W-1:0] req_accel_y,
   input  wire logic signed [aac_pkg::AXIS_W-1:0] req_accel_z,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [aac_pkg::ROOT_W-1:0]             rsp_magnitude,
   output logic [1:0]                             rsp_activity,
   output logic                                   rsp_decided,
   input  wire logic                              csr_write_en,
   input  wire logic [aac_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [aac_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import aac_pkg::*;

   // Configuration registers.
   logic [AXIS_W-1:0]     bias_ff [NUM_AXES];
   logic [AXIS_W-1:0]     bias_in [NUM_AXES];
   logic [CSR_DATA_W-1:0] alpha_ff, alpha_in;
   logic [CSR_DATA_W-1:0] peak_thr_ff, peak_thr_in;
   logic [CSR_DATA_W-1:0] run_thr_ff, run_thr_in;
   logic [CSR_DATA_W-1:0] walk_thr_ff, walk_thr_in;
   logic [COUNT_W-1:0]    window_ff, window_in;

   // Sequencer and datapath registers.
   state_type             state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [AXIS_W-1:0]     mplier_ff [NUM_AXES];
   logic [AXIS_W-1:0]     mplier_in [NUM_AXES];
   logic [SQ_W-1:0]       mcand_ff [NUM_AXES];
   logic [SQ_W-1:0]       mcand_in [NUM_AXES];
   logic [SQ_W-1:0]       square_ff [NUM_AXES];
   logic [SQ_W-1:0]       square_in [NUM_AXES];
   logic [ROOT_W-1:0]     mag_ff, mag_in;
   logic [PROD_W-1:0]     ema_acc_ff, ema_acc_in;
   logic [PROD_W-1:0]     ema_mc_ff, ema_mc_in;
   logic [CSR_DATA_W-1:0] weight_ff, weight_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic [LEVEL_W-1:0]    dev16_ff, dev16_in;
   logic [SUM_W-1:0]      dev_sum_ff, dev_sum_in;
   logic [COUNT_W-1:0]    win_count_ff, win_count_in;
   logic [COUNT_W-1:0]    peak_count_ff, peak_count_in;
   logic                  close_ff, close_in;
   logic [SUM_W-1:0]      run_prod_ff, run_prod_in;
   logic [SUM_W-1:0]      walk_prod_ff, walk_prod_in;
   activity_type          activity_ff, activity_in;
   logic                  decided_ff, decided_in;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ROOT_W-1:0]     rsp_mag_ff, rsp_mag_in;
   activity_type          rsp_act_ff, rsp_act_in;
   logic                  rsp_dec_ff, rsp_dec_in;

   // Square root unit.
   logic                  root_start;
   logic [SQ_W-1:0]       root_radicand;
   logic                  root_done;
   logic [ROOT_W-1:0]     root_value;

   logic [AXIS_W-1:0]     raw [NUM_AXES];
   logic [AXIS_W-1:0]     lane_abs [NUM_AXES];

   assign raw[0] = req_accel_x;
   assign raw[1] = req_accel_y;
   assign raw[2] = req_accel_z;

   // Bias removal with saturation to 16 bits, then magnitude of each axis.
   always_comb begin
      logic [AXIS_W:0]   diff_w;
      logic [AXIS_W-1:0] sat;
      for (int i = 0; i < NUM_AXES; i++) begin
         diff_w = {raw[i][AXIS_W-1], raw[i]} - {bias_ff[i][AXIS_W-1], bias_ff[i]};
         if (diff_w[AXIS_W] != diff_w[AXIS_W-1]) begin
            sat = diff_w[AXIS_W] ? {1'b1, {(AXIS_W-1){1'b0}}} : {1'b0, {(AXIS_W-1){1'b1}}};
         end else begin
            sat = diff_w[AXIS_W-1:0];
         end
         lane_abs[i] = sat[AXIS_W-1] ? (~sat + 1'b1) : sat;
      end
   end

   // Configuration writes.
   always_comb begin
      bias_in     = bias_ff;
      alpha_in    = alpha_ff;
      peak_thr_in = peak_thr_ff;
      run_thr_in  = run_thr_ff;
      walk_thr_in = walk_thr_ff;
      window_in   = window_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_BIAS_X: bias_in[0]  = csr_wdata;
            REG_BIAS_Y: bias_in[1]  = csr_wdata;
            REG_BIAS_Z: bias_in[2]  = csr_wdata;
            REG_ALPHA:  alpha_in    = csr_wdata;
            REG_PEAK:   peak_thr_in = csr_wdata;
            REG_RUN:    run_thr_in  = csr_wdata;
            REG_WALK:   walk_thr_in = csr_wdata;
            REG_WINDOW: window_in   = csr_wdata[COUNT_W-1:0];
            default:    ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // Sequencer and datapath.
   always_comb begin
      logic [DIFF_W-1:0]  mag_diff;
      logic [DIFF_W-1:0]  dev_diff;
      logic [DIFF_W-1:0]  dev_round;
      logic [AXIS_W:0]    dev8_w;
      logic [AXIS_W-1:0]  dev8;
      logic [SUM_W:0]     sum_w;
      logic [COUNT_W-1:0] count_next;
      logic [COUNT_W-1:0] window_len;

      state_in      = state_ff;
      step_in       = step_ff;
      mplier_in     = mplier_ff;
      mcand_in      = mcand_ff;
      square_in     = square_ff;
      mag_in        = mag_ff;
      ema_acc_in    = ema_acc_ff;
      ema_mc_in     = ema_mc_ff;
      weight_in     = weight_ff;
      level_in      = level_ff;
      dev16_in      = dev16_ff;
      dev_sum_in    = dev_sum_ff;
      win_count_in  = win_count_ff;
      peak_count_in = peak_count_ff;
      close_in      = close_ff;
      run_prod_in   = run_prod_ff;
      walk_prod_in  = walk_prod_ff;
      activity_in   = activity_ff;
      decided_in    = decided_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_mag_in    = rsp_mag_ff;
      rsp_act_in    = rsp_act_ff;
      rsp_dec_in    = rsp_dec_ff;
      root_start    = 1'b0;
      root_radicand = square_ff[0] + square_ff[1] + square_ff[2];

      mag_diff   = {1'b0, root_value, 8'b0} - {1'b0, level_ff};
      dev_diff   = {1'b0, mag_ff, 8'b0} - {1'b0, ema_acc_ff[LEVEL_W+15:16]};
      dev_round  = {1'b0, dev16_ff} + DIFF_W'(128);
      dev8_w     = dev_round[DIFF_W-1:8];
      dev8       = dev8_w[AXIS_W] ? {AXIS_W{1'b1}} : dev8_w[AXIS_W-1:0];
      sum_w      = {1'b0, dev_sum_ff} + (SUM_W + 1)'(dev8);
      count_next = (win_count_ff != COUNT_MAX) ? win_count_ff + 1'b1 : win_count_ff;
      window_len = (window_ff == '0) ? COUNT_W'(1) : window_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               for (int i = 0; i < NUM_AXES; i++) begin
                  mplier_in[i] = lane_abs[i];
                  mcand_in[i]  = SQ_W'(lane_abs[i]);
                  square_in[i] = '0;
               end
               step_in  = '0;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            // One multiplier bit per cycle in each of the three lanes.
            for (int i = 0; i < NUM_AXES; i++) begin
               if (mplier_ff[i][0]) begin
                  square_in[i] = square_ff[i] + mcand_ff[i];
               end
               mcand_in[i]  = mcand_ff[i] << 1;
               mplier_in[i] = mplier_ff[i] >> 1;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            root_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_done) begin
               // level + alpha * (m - level), with the rounding half folded in.
               mag_in     = root_value;
               ema_mc_in  = {{(PROD_W - DIFF_W){mag_diff[DIFF_W-1]}}, mag_diff};
               ema_acc_in = {2'b00, level_ff, 16'h8000};
               weight_in  = alpha_ff;
               step_in    = '0;
               state_in   = ST_SMOOTH;
            end
         end
         ST_SMOOTH: begin
            if (weight_ff[0]) begin
               ema_acc_in = ema_acc_ff + ema_mc_ff;
            end
            ema_mc_in = ema_mc_ff << 1;
            weight_in = weight_ff >> 1;
            step_in   = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_DEVIATION;
            end
         end
         ST_DEVIATION: begin
            level_in = ema_acc_ff[LEVEL_W+15:16];
            dev16_in = dev_diff[DIFF_W-1] ? LEVEL_W'(~dev_diff + 1'b1)
                                          : dev_diff[LEVEL_W-1:0];
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            dev_sum_in   = sum_w[SUM_W] ? {SUM_W{1'b1}} : sum_w[SUM_W-1:0];
            win_count_in = count_next;
            if (dev8 > peak_thr_ff && peak_count_ff != COUNT_MAX) begin
               peak_count_in = peak_count_ff + 1'b1;
            end
            close_in = (count_next >= window_len);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            run_prod_in  = SUM_W'(run_thr_ff) * SUM_W'(win_count_ff);
            walk_prod_in = SUM_W'(walk_thr_ff) * SUM_W'(win_count_ff);
            state_in     = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            decided_in = close_ff;
            if (close_ff) begin
               if (peak_count_ff >= RUN_PEAKS || dev_sum_ff > run_prod_ff) begin
                  activity_in = ACT_RUN;
               end else if (dev_sum_ff >= walk_prod_ff) begin
                  activity_in = ACT_WALK;
               end else begin
                  activity_in = ACT_REST;
               end
               dev_sum_in    = '0;
               win_count_in  = '0;
               peak_count_in = '0;
            end
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_mag_in   = mag_ff;
               rsp_act_in   = activity_ff;
               rsp_dec_in   = decided_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff[0]    <= BIAS_X_RESET;
         bias_ff[1]    <= BIAS_Y_RESET;
         bias_ff[2]    <= BIAS_Z_RESET;
         alpha_ff      <= ALPHA_RESET;
         peak_thr_ff   <= PEAK_RESET;
         run_thr_ff    <= RUN_RESET;
         walk_thr_ff   <= WALK_RESET;
         window_ff     <= WINDOW_RESET;
         state_ff      <= ST_IDLE;
         level_ff      <= LEVEL_RESET;
         dev_sum_ff    <= '0;
         win_count_ff  <= '0;
         peak_count_ff <= '0;
         activity_ff   <= ACT_REST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bias_ff       <= bias_in;
         alpha_ff      <= alpha_in;
         peak_thr_ff   <= peak_thr_in;
         run_thr_ff    <= run_thr_in;
         walk_thr_ff   <= walk_thr_in;
         window_ff     <= window_in;
         state_ff      <= state_in;
         level_ff      <= level_in;
         dev_sum_ff    <= dev_sum_in;
         win_count_ff  <= win_count_in;
         peak_count_ff <= peak_count_in;
         activity_ff   <= activity_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      step_ff      <= step_in;
      mplier_ff    <= mplier_in;
      mcand_ff     <= mcand_in;
      square_ff    <= square_in;
      mag_ff       <= mag_in;
      ema_acc_ff   <= ema_acc_in;
      ema_mc_ff    <= ema_mc_in;
      weight_ff    <= weight_in;
      dev16_ff     <= dev16_in;
      close_ff     <= close_in;
      run_prod_ff  <= run_prod_in;
      walk_prod_ff <= walk_prod_in;
      decided_ff   <= decided_in;
      rsp_mag_ff   <= rsp_mag_in;
      rsp_act_ff   <= rsp_act_in;
      rsp_dec_ff   <= rsp_dec_in;
   end

   aac_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (root_radicand),
      .done     (root_done),
      .root     (root_value)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = rsp_mag_ff;
   assign rsp_activity  = rsp_act_ff;
   assign rsp_decided   = rsp_dec_ff;

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the accelerometer activity classifier.
`timescale 1ns / 1ps

module testbench;
   import aac_pkg::*;

   // The run is cut off here if responses stop coming; this is several times the
   // slowest legal run of about 1700 requests plus stalls.
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned HOLD_OFF_AT   = 600;
   localparam int unsigned HOLD_OFF_LEN  = 700;
   localparam int unsigned DRAIN_CYCLES  = 60;
   localparam int unsigned REPORT_LIMIT  = 10;
   localparam int          GRAVITY_Q78   = 2511;

   typedef struct packed {
      logic signed [AXIS_W-1:0] x;
      logic signed [AXIS_W-1:0] y;
      logic signed [AXIS_W-1:0] z;
   } axis_sample_type;

   typedef struct packed {
      logic [ROOT_W-1:0] magnitude;
      activity_type      activity;
      logic              decided;
   } sample_result_type;

   logic clock;
   logic reset = 1'b1;

   logic                     req_valid   = 1'b0;
   logic                     req_ready;
   logic signed [AXIS_W-1:0] req_accel_x = '0;
   logic signed [AXIS_W-1:0] req_accel_y = '0;
   logic signed [AXIS_W-1:0] req_accel_z = '0;
   logic                     rsp_valid;
   logic                     rsp_ready   = 1'b0;
   logic [ROOT_W-1:0]        rsp_magnitude;
   logic [1:0]               rsp_activity;
   logic                     rsp_decided;
   logic                     csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index    = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata    = '0;

   accel_activity_classifier_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_accel_x  (req_accel_x),
      .req_accel_y  (req_accel_y),
      .req_accel_z  (req_accel_z),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_magnitude(rsp_magnitude),
      .rsp_activity (rsp_activity),
      .rsp_decided  (rsp_decided),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Samples waiting to be offered, and the responses predicted for the
   // requests that the block has already accepted, oldest first.
   axis_sample_type   pending_samples[$];
   sample_result_type expected_results[$];

   int unsigned cycle_count     = 0;
   int unsigned failure_count   = 0;
   int unsigned responses_seen  = 0;
   int unsigned hold_left       = 0;
   bit          hold_off_done   = 1'b0;
   // While set, neither side of the block idles.
   bit          steady_flow     = 1'b0;

   // Our own copy of the configuration registers, kept in step with every write.
   logic signed [AXIS_W-1:0] cfg_bias_x = BIAS_X_RESET;
   logic signed [AXIS_W-1:0] cfg_bias_y = BIAS_Y_RESET;
   logic signed [AXIS_W-1:0] cfg_bias_z = BIAS_Z_RESET;
   logic [CSR_DATA_W-1:0]    cfg_alpha  = ALPHA_RESET;
   logic [CSR_DATA_W-1:0]    cfg_peak   = PEAK_RESET;
   logic [CSR_DATA_W-1:0]    cfg_run    = RUN_RESET;
   logic [CSR_DATA_W-1:0]    cfg_walk   = WALK_RESET;
   logic [COUNT_W-1:0]       cfg_window = WINDOW_RESET;

   // Our own copy of the classifier state, at its reset values.
   logic [LEVEL_W-1:0] level_q816  = LEVEL_RESET;
   logic [SUM_W-1:0]   dev_total   = '0;
   logic [COUNT_W-1:0] win_samples = '0;
   logic [COUNT_W-1:0] win_peaks   = '0;
   activity_type       act_now     = ACT_REST;

   axis_sample_type   head_sample;
   sample_result_type seen_result;
   sample_result_type want_result;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int clamp_axis(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic int rand_between(input int lo, input int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // Works out the response to one sample and advances the window state. The
   // magnitude is the floor square root found one result bit at a time, the
   // average is an alpha-weighted blend rounded half up, and the window closes
   // once its sample count reaches the window length (zero counts as one).
   function automatic sample_result_type classify_sample(
                                                 input logic signed [AXIS_W-1:0] ax,
                                                 input logic signed [AXIS_W-1:0] ay,
                                                 input logic signed [AXIS_W-1:0] az);
      int                cx, cy, cz;
      longint unsigned   energy, cand, m16, blended, dev16, dev8, total, alpha, n;
      logic [ROOT_W-1:0] root;
      int unsigned       window_len;
      sample_result_type res;
      cx = clamp_axis(int'(ax) - int'(cfg_bias_x));
      cy = clamp_axis(int'(ay) - int'(cfg_bias_y));
      cz = clamp_axis(int'(az) - int'(cfg_bias_z));
      energy = longint'(cx * cx) + longint'(cy * cy) + longint'(cz * cz);
      root = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         cand = longint'(root) | (64'd1 << b);
         if (cand * cand <= energy) root = cand[ROOT_W-1:0];
      end
      m16 = longint'(root) << 8;
      alpha = longint'(cfg_alpha);
      blended = (alpha * m16 + (64'd65536 - alpha) * longint'(level_q816) + 64'd32768) >> 16;
      level_q816 = blended[LEVEL_W-1:0];
      dev16 = (m16 >= longint'(level_q816)) ? m16 - longint'(level_q816)
                                            : longint'(level_q816) - m16;
      dev8 = (dev16 + 64'd128) >> 8;
      if (dev8 > 64'hFFFF) dev8 = 64'hFFFF;
      total = longint'(dev_total) + dev8;
      dev_total = (total > 64'hFF_FFFF) ? {SUM_W{1'b1}} : total[SUM_W-1:0];
      if (win_samples != COUNT_MAX) win_samples = win_samples + 1'b1;
      if (dev8 > longint'(cfg_peak) && win_peaks != COUNT_MAX) win_peaks = win_peaks + 1'b1;
      window_len = (cfg_window == '0) ? 1 : int'(cfg_window);
      res.decided = 1'b0;
      if (int'(win_samples) >= window_len) begin
         n = longint'(win_samples);
         if (win_peaks >= RUN_PEAKS || longint'(dev_total) > longint'(cfg_run) * n)
            act_now = ACT_RUN;
         else if (longint'(dev_total) >= longint'(cfg_walk) * n)
            act_now = ACT_WALK;
         else
            act_now = ACT_REST;
         dev_total   = '0;
         win_samples = '0;
         win_peaks   = '0;
         res.decided = 1'b1;
      end
      res.magnitude = root;
      res.activity  = act_now;
      return res;
   endfunction

   task automatic note_failure(input string what, input sample_result_type want,
                               input sample_result_type got);
      if (failure_count < REPORT_LIMIT) begin
         $display("%s: expected magnitude %0d activity %0d decided %0b,", what,
                  want.magnitude, want.activity, want.decided);
         $display("   got magnitude %0d activity %0d decided %0b at cycle %0d",
                  got.magnitude, got.activity, got.decided, cycle_count);
      end
      failure_count++;
   endtask

   // Request driver. A new request goes out only when the bus is free or the
   // current one is being accepted, so valid is never lowered under a waiting
   // request. The response is predicted at the edge that accepts the request.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(classify_sample(req_accel_x, req_accel_y,
                                                       req_accel_z));
         end
         if (!req_valid || req_ready) begin
            if (pending_samples.size() != 0 &&
                (steady_flow || $urandom_range(99) >= 36)) begin
               head_sample = pending_samples.pop_front();
               req_valid   <= 1'b1;
               req_accel_x <= head_sample.x;
               req_accel_y <= head_sample.y;
               req_accel_z <= head_sample.z;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response ready. Once, after a few hundred responses, the receiver holds off
   // for a long stretch while the driver keeps offering requests, so the output
   // register and then the request side of the block both stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_off_done && responses_seen == HOLD_OFF_AT) begin
         rsp_ready     <= 1'b0;
         hold_left     <= HOLD_OFF_LEN;
         hold_off_done <= 1'b1;
      end else begin
         rsp_ready <= steady_flow || ($urandom_range(99) >= 36);
      end
   end

   // Response checker: every accepted response is held against the oldest
   // prediction, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen <= responses_seen + 1;
         seen_result.magnitude = rsp_magnitude;
         seen_result.activity  = activity_type'(rsp_activity);
         seen_result.decided   = rsp_decided;
         if (expected_results.size() == 0) begin
            note_failure("response with no request outstanding", '0, seen_result);
         end else begin
            want_result = expected_results.pop_front();
            if (seen_result.magnitude !== want_result.magnitude ||
                rsp_activity !== want_result.activity ||
                seen_result.decided !== want_result.decided) begin
               note_failure("response mismatch", want_result, seen_result);
            end
         end
      end
   end

   // Watchdog: a hung block ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Register write; our copy of the register changes with the block's. Bits of
   // the write data above a register's width are dropped, as the block does.
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      case (idx)
         REG_BIAS_X: cfg_bias_x = value;
         REG_BIAS_Y: cfg_bias_y = value;
         REG_BIAS_Z: cfg_bias_z = value;
         REG_ALPHA:  cfg_alpha  = value;
         REG_PEAK:   cfg_peak   = value;
         REG_RUN:    cfg_run    = value;
         REG_WALK:   cfg_walk   = value;
         REG_WINDOW: cfg_window = value[COUNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Waits until every sample has been accepted and every response checked.
   // Each request yields a response, so the block is idle at that point.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic queue_sample(input int x, input int y, input int z);
      axis_sample_type s;
      s.x = x[AXIS_W-1:0];
      s.y = y[AXIS_W-1:0];
      s.z = z[AXIS_W-1:0];
      pending_samples.push_back(s);
   endtask

   // A sample that looks like real motion: gravity on Z after the biases, with
   // a jitter whose size sets how vigorous the motion is.
   task automatic queue_motion(input int amp);
      queue_sample(clamp_axis(int'(cfg_bias_x) + rand_between(-amp, amp)),
                   clamp_axis(int'(cfg_bias_y) + rand_between(-amp, amp)),
                   clamp_axis(int'(cfg_bias_z) + GRAVITY_Q78 + rand_between(-amp, amp)));
   endtask

   // Picks a register value: mostly within a useful range, sometimes an extreme.
   function automatic logic [CSR_DATA_W-1:0] pick_value(input int lo, input int hi,
                                                       input logic [CSR_DATA_W-1:0] lo_end,
                                                       input logic [CSR_DATA_W-1:0] hi_end);
      int unsigned r;
      int          v;
      r = $urandom_range(5);
      if (r == 0) return lo_end;
      if (r == 1) return hi_end;
      v = rand_between(lo, hi);
      return v[CSR_DATA_W-1:0];
   endfunction

   // One random phase: a fresh setting of every register, then motion-like
   // samples at one intensity with a share of completely random samples.
   task automatic run_random_phase(input int count);
      int          amp;
      int unsigned pick;
      logic [7:0]  upper;
      write_reg(REG_BIAS_X, pick_value(-600, 600, 16'h8000, 16'h7FFF));
      write_reg(REG_BIAS_Y, pick_value(-600, 600, 16'h8000, 16'h7FFF));
      write_reg(REG_BIAS_Z, pick_value(-5000, -3800, 16'h8000, 16'h7FFF));
      write_reg(REG_ALPHA, pick_value(500, 20000, 16'h0000, 16'hFFFF));
      write_reg(REG_PEAK, pick_value(0, 3000, 16'h0000, 16'hFFFF));
      write_reg(REG_RUN, pick_value(0, 1500, 16'h0000, 16'hFFFF));
      write_reg(REG_WALK, pick_value(0, 600, 16'h0000, 16'hFFFF));
      upper = 8'($urandom);
      pick  = $urandom_range(9);
      if (pick == 0)
         write_reg(REG_WINDOW, {upper, 8'd0});
      else if (pick == 1)
         write_reg(REG_WINDOW, {upper, 8'd255});
      else if (pick == 2)
         write_reg(REG_WINDOW, {upper, 8'd1});
      else
         write_reg(REG_WINDOW, {upper, 8'(rand_between(2, 16))});
      case ($urandom_range(4))
         0:       amp = 32;
         1:       amp = 200;
         2:       amp = 800;
         3:       amp = 3000;
         default: amp = 12000;
      endcase
      @(negedge clock);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) < 2)
            queue_sample(int'($urandom), int'($urandom), int'($urandom));
         else
            queue_motion(amp);
      end
      wait_idle();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset setting: extremes of every axis, a sample that cancels the biases
      // exactly, corrected differences that saturate both ways, one at rest.
      queue_sample(0, 0, 0);
      queue_sample(32767, 32767, 32767);
      queue_sample(-32768, -32768, -32768);
      queue_sample(32767, -32768, 0);
      queue_sample(58, 79, -4439);
      queue_sample(-32768, 32767, 32767);
      queue_sample(58, 79, -1928);
      queue_sample(-1, -1, -1);
      wait_idle();

      // Extreme registers with a zero window length, so every sample closes a
      // window. The upper data byte on the window write must be dropped.
      write_reg(REG_BIAS_X, 16'h8000);
      write_reg(REG_BIAS_Y, 16'h7FFF);
      write_reg(REG_BIAS_Z, 16'h0000);
      write_reg(REG_ALPHA, 16'hFFFF);
      write_reg(REG_PEAK, 16'h0000);
      write_reg(REG_RUN, 16'h0000);
      write_reg(REG_WALK, 16'h0000);
      write_reg(REG_WINDOW, 16'hFF00);
      @(negedge clock);
      queue_sample(-32768, 32767, 0);
      queue_sample(-32768, 32767, 0);
      queue_sample(32767, -32768, 32767);
      queue_sample(0, 0, 0);
      wait_idle();

      // The opposite extremes: an average that never moves and thresholds at full scale.
      write_reg(REG_BIAS_X, 16'h0000);
      write_reg(REG_BIAS_Y, 16'h0000);
      write_reg(REG_ALPHA, 16'h0000);
      write_reg(REG_PEAK, 16'hFFFF);
      write_reg(REG_RUN, 16'hFFFF);
      write_reg(REG_WALK, 16'hFFFF);
      write_reg(REG_WINDOW, 16'h5A01);
      @(negedge clock);
      queue_sample(32767, 32767, 32767);
      queue_sample(-32768, -32768, -32768);
      queue_sample(0, 0, 0);
      wait_idle();

      // A long window left partly full, then shortened: the very next sample has
      // to close it.
      write_reg(REG_BIAS_Z, 16'hEEA9);
      write_reg(REG_ALPHA, 16'd3277);
      write_reg(REG_PEAK, 16'd256);
      write_reg(REG_RUN, 16'd512);
      write_reg(REG_WALK, 16'd128);
      write_reg(REG_WINDOW, 16'd200);
      @(negedge clock);
      for (int i = 0; i < 6; i++) queue_motion(1000);
      wait_idle();
      write_reg(REG_WINDOW, 16'd3);
      @(negedge clock);
      for (int i = 0; i < 3; i++) queue_motion(1000);
      wait_idle();

      // Longest window with a peak threshold of zero, so the peak counter can climb
      // as far as its ceiling by the sample that closes the window.
      write_reg(REG_WINDOW, 16'd255);
      write_reg(REG_PEAK, 16'd0);
      write_reg(REG_RUN, 16'hFFFF);
      write_reg(REG_WALK, 16'hFFFF);
      @(negedge clock);
      for (int i = 0; i < 260; i++) queue_motion(3000);
      wait_idle();

      // Random phases; one of them runs with no idling on either side.
      for (int p = 0; p < 10; p++) begin
         steady_flow = (p == 4);
         run_random_phase(142);
      end
      steady_flow = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failure_count == 0 && expected_results.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// File: files.f
rtl/aac_pkg.sv
rtl/aac_isqrt.sv
rtl/accel_activity_classifier_top.sv
dv/testbench.sv
